// ===== src/vnorm_pkg.sv =====
// Shared constants for the vector normalisation block.
`default_nettype none
package vnorm_pkg;
    localparam int DEF_COMPONENT_WIDTH = 32;
    localparam int DEF_FRAC_BITS       = 16;
    localparam int THR_WIDTH           = 32;
    localparam int LEN_WIDTH           = 32;
    localparam int NUM_COMP            = 4;
    localparam logic [THR_WIDTH-1:0] THR_RESET = 32'd42950;
    // Vector size codes on op.
    localparam logic OP_THREE = 1'b0;
    localparam logic OP_FOUR  = 1'b1;
endpackage
`default_nettype wire

// ===== src/vector_normalize.sv =====
// Top level: pipelined length and unit vector of a 3- or 4-component vector.
//
// Usage: drive op and the four components and pulse start; a word is taken at
// every clock edge with start high and busy low. busy never rises, so one word
// may enter in every cycle. The result appears on the output ports for exactly
// one cycle, marked by done; the receiver cannot hold it off.
// A word passes three stages for magnitudes, squares and the sum, one stage per
// root bit of the restoring square root (COMPONENT_WIDTH+1 stages), one per
// quotient bit of the four restoring dividers (FRAC_BITS+1 stages) and the
// output register, which drives done.
// Throughput is one word per cycle; the depth is set by the bit-per-stage root
// and divider chains.
// thr_reg is written by cfg_we/cfg_wdata; the user must write it only while no
// word is in flight, the block does not enforce this. Reset clears all valid
// bits and loads the threshold default; words in flight at reset are dropped.
`default_nettype none
module vector_normalize
    import vnorm_pkg::*;
#(
    parameter int COMPONENT_WIDTH = DEF_COMPONENT_WIDTH,
    parameter int FRAC_BITS       = DEF_FRAC_BITS
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              cfg_we,
    input  wire logic [THR_WIDTH-1:0]              cfg_wdata,
    input  wire logic                              op,
    input  wire logic signed [COMPONENT_WIDTH-1:0] x_in,
    input  wire logic signed [COMPONENT_WIDTH-1:0] y_in,
    input  wire logic signed [COMPONENT_WIDTH-1:0] z_in,
    input  wire logic signed [COMPONENT_WIDTH-1:0] w_in,
    output logic                                   done,
    output logic signed [COMPONENT_WIDTH-1:0]      x_out,
    output logic signed [COMPONENT_WIDTH-1:0]      y_out,
    output logic signed [COMPONENT_WIDTH-1:0]      z_out,
    output logic signed [COMPONENT_WIDTH-1:0]      w_out,
    output logic [LEN_WIDTH-1:0]                   length,
    output logic                                   too_small
);
    localparam int CW    = COMPONENT_WIDTH;
    localparam int RW    = CW + 1;
    localparam int SW    = 2 * RW;
    localparam int DS    = FRAC_BITS + 1;
    localparam int THR_SH = (2 * FRAC_BITS >= 32) ? 2 * FRAC_BITS - 32 : 0;
    localparam int SUM_SH = (2 * FRAC_BITS < 32) ? 32 - 2 * FRAC_BITS : 0;
    localparam int CMPW  = SW + THR_WIDTH + 2 * FRAC_BITS;
    // Carried payload: raw components, magnitudes, signs, op, small flag.
    localparam int RAW_LO = 0;
    localparam int MAG_LO = NUM_COMP * CW;
    localparam int NEG_LO = 2 * NUM_COMP * CW;
    localparam int OP_B   = NEG_LO + NUM_COMP;
    localparam int SM_B   = OP_B + 1;
    localparam int PW     = SM_B + 1;

    logic [THR_WIDTH-1:0] thr_reg;
    logic [PW-1:0]        p1_reg, p2_reg, p3_reg;
    logic                 v1_reg, v2_reg, v3_reg;
    logic [2*CW-1:0]      sq_reg [NUM_COMP];
    logic [SW-1:0]        sum_reg;
    logic [PW-1:0]        p1_next;
    logic [CW-1:0]        comp_in [NUM_COMP];

    // Nothing ever holds the input off.
    assign busy = 1'b0;

    // Threshold register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    // Stage one: signs and magnitudes; w drops out of a three-component word.
    assign comp_in[0] = x_in;
    assign comp_in[1] = y_in;
    assign comp_in[2] = z_in;
    assign comp_in[3] = w_in;
    always_comb
    begin
        p1_next = '0;
        for (int i = 0; i < NUM_COMP; i++)
        begin
            p1_next[RAW_LO + i*CW +: CW] = comp_in[i];
            p1_next[NEG_LO + i]          = comp_in[i][CW-1];
            p1_next[MAG_LO + i*CW +: CW] = comp_in[i][CW-1] ? (~comp_in[i] + 1'b1)
                                                            : comp_in[i];
        end
        if (op == OP_THREE)
        begin
            p1_next[MAG_LO + 3*CW +: CW] = '0;
        end
        p1_next[OP_B] = op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stages two and three: squares, then their sum and the threshold compare.
    always_ff @(posedge clk)
    begin
        p1_reg <= p1_next;
        for (int i = 0; i < NUM_COMP; i++)
        begin
            sq_reg[i] <= p1_reg[MAG_LO + i*CW +: CW] * p1_reg[MAG_LO + i*CW +: CW];
        end
        p2_reg <= p1_reg;
        sum_reg <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]) + SW'(sq_reg[3]);
        p3_reg <= {(CMPW'(thr_reg) << THR_SH)
                   > (CMPW'(SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2])
                            + SW'(sq_reg[3])) << SUM_SH),
                   p2_reg[SM_B-1:0]};
    end

    // Square root: one result bit per stage, restoring.
    logic          sv_reg   [RW+1];
    logic [SW-1:0] rad_reg  [RW+1];
    logic [RW+1:0] rem_reg  [RW+1];
    logic [RW-1:0] root_reg [RW+1];
    logic [PW-1:0] sp_reg   [RW+1];

    assign sv_reg[0]   = v3_reg;
    assign rad_reg[0]  = sum_reg;
    assign rem_reg[0]  = '0;
    assign root_reg[0] = '0;
    assign sp_reg[0]   = p3_reg;

    for (genvar j = 0; j < RW; j++)
    begin : g_root
        logic [RW+1:0] acc, trial;
        always_comb
        begin
            acc   = {rem_reg[j][RW-1:0], rad_reg[j][SW-1 -: 2]};
            trial = {root_reg[j], 2'b01};
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sv_reg[j+1] <= 1'b0;
            end
            else
            begin
                sv_reg[j+1] <= sv_reg[j];
            end
        end
        always_ff @(posedge clk)
        begin
            rad_reg[j+1] <= rad_reg[j] << 2;
            sp_reg[j+1]  <= sp_reg[j];
            if (acc >= trial)
            begin
                rem_reg[j+1]  <= acc - trial;
                root_reg[j+1] <= {root_reg[j][RW-2:0], 1'b1};
            end
            else
            begin
                rem_reg[j+1]  <= acc;
                root_reg[j+1] <= {root_reg[j][RW-2:0], 1'b0};
            end
        end
    end

    // Division of each magnitude by the length, one quotient bit per stage.
    // A magnitude never exceeds the length, so the quotient has DS bits.
    logic          dv_reg  [DS+1];
    logic [RW-1:0] dlen_reg[DS+1];
    logic [PW-1:0] dp_reg  [DS+1];
    logic [RW-1:0] drem_reg[NUM_COMP][DS+1];
    logic [DS-1:0] dq_reg  [NUM_COMP][DS+1];

    assign dv_reg[0]   = sv_reg[RW];
    assign dlen_reg[0] = root_reg[RW];
    assign dp_reg[0]   = sp_reg[RW];

    for (genvar c = 0; c < NUM_COMP; c++)
    begin : g_comp
        assign drem_reg[c][0] = RW'(sp_reg[RW][MAG_LO + c*CW +: CW]);
        assign dq_reg[c][0]   = '0;
        for (genvar k = 0; k < DS; k++)
        begin : g_div
            logic [RW:0] part;
            always_comb
            begin
                if (k == 0)
                begin
                    part = {1'b0, drem_reg[c][k]};
                end
                else
                begin
                    part = {drem_reg[c][k], 1'b0};
                end
            end
            always_ff @(posedge clk)
            begin
                if (part >= {1'b0, dlen_reg[k]})
                begin
                    drem_reg[c][k+1] <= RW'(part - {1'b0, dlen_reg[k]});
                    dq_reg[c][k+1]   <= {dq_reg[c][k][DS-2:0], 1'b1};
                end
                else
                begin
                    drem_reg[c][k+1] <= RW'(part);
                    dq_reg[c][k+1]   <= {dq_reg[c][k][DS-2:0], 1'b0};
                end
            end
        end
    end

    for (genvar k = 0; k < DS; k++)
    begin : g_dctl
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[k+1] <= 1'b0;
            end
            else
            begin
                dv_reg[k+1] <= dv_reg[k];
            end
        end
        always_ff @(posedge clk)
        begin
            dlen_reg[k+1] <= dlen_reg[k];
            dp_reg[k+1]   <= dp_reg[k];
        end
    end

    // Output register: choose pass-through, zero or signed quotient.
    logic [CW-1:0]        res_next [NUM_COMP];
    logic [CW-1:0]        res_reg  [NUM_COMP];
    logic [LEN_WIDTH-1:0] len_next, len_reg;
    logic                 small_reg, done_reg;
    logic [PW-1:0]        fin;
    logic [CW+DS-1:0]     qext;

    assign fin = dp_reg[DS];

    always_comb
    begin
        qext = '0;
        for (int i = 0; i < NUM_COMP; i++)
        begin
            qext = (CW+DS)'(dq_reg[i][DS]);
            if (i == 3 && fin[OP_B] == OP_THREE)
            begin
                res_next[i] = '0;
            end
            else if (fin[SM_B])
            begin
                res_next[i] = fin[RAW_LO + i*CW +: CW];
            end
            else if (dlen_reg[DS] == '0)
            begin
                res_next[i] = '0;
            end
            else if (fin[NEG_LO + i])
            begin
                res_next[i] = CW'(~qext + 1'b1);
            end
            else
            begin
                res_next[i] = CW'(qext);
            end
        end
        if (RW > LEN_WIDTH && (dlen_reg[DS] >> LEN_WIDTH) != '0)
        begin
            len_next = '1;
        end
        else
        begin
            len_next = LEN_WIDTH'(dlen_reg[DS]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_reg[DS];
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg   <= res_next;
        len_reg   <= len_next;
        small_reg <= fin[SM_B];
    end

    assign done      = done_reg;
    assign x_out     = res_reg[0];
    assign y_out     = res_reg[1];
    assign z_out     = res_reg[2];
    assign w_out     = res_reg[3];
    assign length    = len_reg;
    assign too_small = small_reg;

    // Checks.
    a_done_follows_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(dv_reg[DS]))
        else $error("result word without a word leaving the dividers");
    a_zero_len_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        done && !too_small && length == '0 |-> x_out == '0 && y_out == '0
                                               && z_out == '0 && w_out == '0)
        else $error("zero length gave non-zero components");
    a_sum_stage_follows: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> $past(v2_reg))
        else $error("sum stage valid without a squared word");
endmodule
`default_nettype wire
